// File: rtl/core/caf_pkg.sv
// operation codes and flag type for the accumulator alu
package caf_pkg;

	localparam int ModeW = 5;

	localparam logic [ModeW-1:0] MODE_ADD   = 5'd0;
	localparam logic [ModeW-1:0] MODE_ADC   = 5'd1;
	localparam logic [ModeW-1:0] MODE_SUB   = 5'd2;
	localparam logic [ModeW-1:0] MODE_SBC   = 5'd3;
	localparam logic [ModeW-1:0] MODE_AND   = 5'd4;
	localparam logic [ModeW-1:0] MODE_XOR   = 5'd5;
	localparam logic [ModeW-1:0] MODE_OR    = 5'd6;
	localparam logic [ModeW-1:0] MODE_CP    = 5'd7;
	localparam logic [ModeW-1:0] MODE_INC   = 5'd8;
	localparam logic [ModeW-1:0] MODE_DEC   = 5'd9;
	localparam logic [ModeW-1:0] MODE_RLCA  = 5'd10;
	localparam logic [ModeW-1:0] MODE_RRCA  = 5'd11;
	localparam logic [ModeW-1:0] MODE_RLA   = 5'd12;
	localparam logic [ModeW-1:0] MODE_RRA   = 5'd13;
	localparam logic [ModeW-1:0] MODE_DAA   = 5'd14;
	localparam logic [ModeW-1:0] MODE_CPL   = 5'd15;
	localparam logic [ModeW-1:0] MODE_SCF   = 5'd16;
	localparam logic [ModeW-1:0] MODE_CCF   = 5'd17;
	localparam logic [ModeW-1:0] MODE_ADD16 = 5'd18;
	localparam logic [ModeW-1:0] MODE_LDA   = 5'd19;

	localparam logic [7:0] DAA_LO_ADJ = 8'h06;
	localparam logic [7:0] DAA_HI_ADJ = 8'h60;
	localparam logic [3:0] DAA_LO_MAX = 4'h9;
	localparam logic [7:0] DAA_MAX    = 8'h99;

	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

endpackage

// File: rtl/core/cpu_accumulator_alu_flags.sv
// sm83 style accumulator alu with z/n/h/c flags, top level
// One request is accepted per cycle while in_stall is low. A request is captured in an input
// register, where the alu evaluates it against the current accumulator and flags; once the
// output is not stalled it loads the result register, and the next request, which sees the
// updated accumulator and flags, can be captured in the same cycle that the result loads.
// The accumulator and flags clear on reset. Mode codes 20 to 31 change nothing and report the
// current accumulator and flags with a zero result.
module cpu_accumulator_alu_flags (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [caf_pkg::ModeW-1:0]  mode,
	input  logic [15:0]                operand,
	input  logic [15:0]                pair_value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 acc_out,
	output logic [15:0]                result,
	output logic                       zero_flag,
	output logic                       subtract_flag,
	output logic                       half_flag,
	output logic                       carry_flag
);
	import caf_pkg::*;

	logic             valid_s1;
	logic [ModeW-1:0] mode_s1;
	logic [15:0]      operand_s1;
	logic [15:0]      pair_s1;

	logic             valid_s2;
	logic [15:0]      result_s2;

	logic [7:0]       acc_q;
	flags_t           flag_q;

	logic             advance;
	logic             take_in;

	logic [7:0]       a;
	logic [7:0]       b;
	logic             cin;
	logic [8:0]       sum9;
	logic [8:0]       diff9;
	logic [16:0]      sum17;
	logic [7:0]       inc8;
	logic [7:0]       dec8;
	logic [7:0]       adj;
	logic [7:0]       daa8;
	logic [7:0]       acc_d;
	flags_t           flag_d;
	logic [15:0]      result_d;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign take_in  = in_valid && !in_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			mode_s1    <= mode;
			operand_s1 <= operand;
			pair_s1    <= pair_value;
		end
	end

	assign a   = acc_q;
	assign b   = operand_s1[7:0];
	assign cin = flag_q.c;

	always_comb begin
		sum9  = {1'b0, a} + {1'b0, b} + {8'd0, (mode_s1 == MODE_ADC) && cin};
		diff9 = {1'b0, a} - {1'b0, b} - {8'd0, (mode_s1 == MODE_SBC) && cin};
		sum17 = {1'b0, pair_s1} + {1'b0, operand_s1};
		inc8  = b + 8'd1;
		dec8  = b - 8'd1;

		adj = 8'd0;
		if (flag_q.h) begin
			adj = adj | DAA_LO_ADJ;
		end
		if (cin) begin
			adj = adj | DAA_HI_ADJ;
		end
		if (flag_q.n) begin
			daa8 = a - adj;
		end else begin
			if (a[3:0] > DAA_LO_MAX) begin
				adj = adj | DAA_LO_ADJ;
			end
			if (a > DAA_MAX) begin
				adj = adj | DAA_HI_ADJ;
			end
			daa8 = a + adj;
		end
	end

	always_comb begin
		acc_d    = acc_q;
		flag_d   = flag_q;
		result_d = 16'd0;
		case (mode_s1) inside
			MODE_ADD, MODE_ADC: begin
				acc_d  = sum9[7:0];
				flag_d = '{z: sum9[7:0] == 8'd0, n: 1'b0,
					h: a[4] ^ b[4] ^ sum9[4], c: sum9[8]};
			end
			MODE_SUB, MODE_SBC, MODE_CP: begin
				if (mode_s1 != MODE_CP) begin
					acc_d = diff9[7:0];
				end
				flag_d = '{z: diff9[7:0] == 8'd0, n: 1'b1,
					h: a[4] ^ b[4] ^ diff9[4], c: diff9[8]};
			end
			MODE_AND: begin
				acc_d  = a & b;
				flag_d = '{z: (a & b) == 8'd0, n: 1'b0, h: 1'b1, c: 1'b0};
			end
			MODE_XOR: begin
				acc_d  = a ^ b;
				flag_d = '{z: (a ^ b) == 8'd0, n: 1'b0, h: 1'b0, c: 1'b0};
			end
			MODE_OR: begin
				acc_d  = a | b;
				flag_d = '{z: (a | b) == 8'd0, n: 1'b0, h: 1'b0, c: 1'b0};
			end
			MODE_INC: begin
				result_d = {8'd0, inc8};
				flag_d   = '{z: inc8 == 8'd0, n: 1'b0, h: b[3:0] == 4'hf, c: cin};
			end
			MODE_DEC: begin
				result_d = {8'd0, dec8};
				flag_d   = '{z: dec8 == 8'd0, n: 1'b1, h: b[3:0] == 4'h0, c: cin};
			end
			MODE_RLCA: begin
				acc_d  = {a[6:0], a[7]};
				flag_d = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
			end
			MODE_RRCA: begin
				acc_d  = {a[0], a[7:1]};
				flag_d = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
			end
			MODE_RLA: begin
				acc_d  = {a[6:0], cin};
				flag_d = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
			end
			MODE_RRA: begin
				acc_d  = {cin, a[7:1]};
				flag_d = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
			end
			MODE_DAA: begin
				acc_d  = daa8;
				flag_d = '{z: daa8 == 8'd0, n: flag_q.n, h: 1'b0, c: adj[6] | adj[5]};
			end
			MODE_CPL: begin
				acc_d  = ~a;
				flag_d = '{z: flag_q.z, n: 1'b1, h: 1'b1, c: flag_q.c};
			end
			MODE_SCF: begin
				flag_d = '{z: flag_q.z, n: 1'b0, h: 1'b0, c: 1'b1};
			end
			MODE_CCF: begin
				flag_d = '{z: flag_q.z, n: 1'b0, h: 1'b0, c: !cin};
			end
			MODE_ADD16: begin
				result_d = sum17[15:0];
				flag_d   = '{z: flag_q.z, n: 1'b0,
					h: pair_s1[12] ^ operand_s1[12] ^ sum17[12], c: sum17[16]};
			end
			MODE_LDA: begin
				acc_d = b;
			end
			default: begin
				acc_d = acc_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			acc_q    <= 8'd0;
			flag_q   <= '0;
		end else begin
			if (advance) begin
				valid_s2 <= 1'b1;
				acc_q    <= acc_d;
				flag_q   <= flag_d;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	// state only moves when the result register loads, so it doubles as the output
	assign out_valid     = valid_s2;
	assign acc_out       = acc_q;
	assign result        = result_s2;
	assign zero_flag     = flag_q.z;
	assign subtract_flag = flag_q.n;
	assign half_flag     = flag_q.h;
	assign carry_flag    = flag_q.c;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(acc_out) && $stable(result))
		else $error("result changed while stalled");

	a_cp_keeps_acc: assert property (@(posedge clk) disable iff (!arst_n)
		advance && mode_s1 == MODE_CP |=> $stable(acc_q))
		else $error("compare changed the accumulator");

	a_rot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (mode_s1 == MODE_RLCA || mode_s1 == MODE_RRCA ||
			mode_s1 == MODE_RLA || mode_s1 == MODE_RRA)
		|=> !zero_flag && !subtract_flag && !half_flag)
		else $error("rotate left z, n or h set");

	a_incdec_carry: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (mode_s1 == MODE_INC || mode_s1 == MODE_DEC) |=> $stable(flag_q.c))
		else $error("inc or dec changed carry");

	a_acc_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		advance && mode_s1 < MODE_INC |=> result == 16'd0)
		else $error("accumulator operation gave a nonzero result");

endmodule

// File: verif/cpu_accumulator_alu_flags_test.sv
// self-checking testbench for the sm83 style accumulator alu with flags
`timescale 1ns / 1ps

module cpu_accumulator_alu_flags_test;
	import caf_pkg::*;

	localparam logic [ModeW-1:0] MODE_NOP = 5'd31;
	localparam int RANDOM_ITEMS = 1900;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int NDIR         = 26;

	typedef struct packed {
		logic [7:0]  acc;
		logic [15:0] res;
		flags_t      fl;
	} alu_out_t;

	typedef struct packed {
		logic [ModeW-1:0] mode;
		logic [15:0]      operand;
		logic [15:0]      pair;
		logic             typed;
		alu_out_t         want;
	} dir_row_t;

	// rows with typed = 1 carry their own expectation, the rest go through the predictor
	localparam dir_row_t DIR_TABLE [NDIR] = '{
		{MODE_NOP,   16'hFFFF, 16'hFFFF, 1'b1, 8'h00, 16'h0000, 4'b0000},
		{MODE_LDA,   16'h12FF, 16'h0000, 1'b1, 8'hFF, 16'h0000, 4'b0000},
		{MODE_ADD,   16'hFF01, 16'hFFFF, 1'b1, 8'h00, 16'h0000, 4'b1011},
		{MODE_ADC,   16'h00FF, 16'h0000, 1'b1, 8'h00, 16'h0000, 4'b1011},
		{MODE_SUB,   16'h0001, 16'h0000, 1'b1, 8'hFF, 16'h0000, 4'b0111},
		{MODE_SBC,   16'hFFFF, 16'h0000, 1'b1, 8'hFF, 16'h0000, 4'b0111},
		{MODE_CP,    16'h00FF, 16'h0000, 1'b1, 8'hFF, 16'h0000, 4'b1100},
		{MODE_AND,   16'hFF00, 16'h0000, 1'b1, 8'h00, 16'h0000, 4'b1010},
		{MODE_OR,    16'h0000, 16'h0000, 1'b1, 8'h00, 16'h0000, 4'b1000},
		{MODE_XOR,   16'h00FF, 16'h0000, 1'b1, 8'hFF, 16'h0000, 4'b0000},
		{MODE_INC,   16'h00FF, 16'h0000, 1'b1, 8'hFF, 16'h0000, 4'b1010},
		{MODE_DEC,   16'h0000, 16'h0000, 1'b1, 8'hFF, 16'h00FF, 4'b0110},
		{MODE_DEC,   16'hAB01, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'b0000},
		{MODE_SCF,   16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'b0000},
		{MODE_RLCA,  16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'b0000},
		{MODE_RRCA,  16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'b0000},
		{MODE_RLA,   16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'b0000},
		{MODE_RRA,   16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'b0000},
		{MODE_CCF,   16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'b0000},
		{MODE_LDA,   16'h009A, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'b0000},
		{MODE_DAA,   16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'b0000},
		{MODE_SUB,   16'h000F, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'b0000},
		{MODE_DAA,   16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'b0000},
		{MODE_CPL,   16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 4'b0000},
		{MODE_ADD16, 16'hFFFF, 16'h0001, 1'b0, 8'h00, 16'h0000, 4'b0000},
		{MODE_ADD16, 16'h0001, 16'h0FFF, 1'b0, 8'h00, 16'h0000, 4'b0000}
	};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [ModeW-1:0] mode = '0;
	logic [15:0]      operand = '0;
	logic [15:0]      pair_value = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [7:0]       acc_out;
	logic [15:0]      result;
	logic             zero_flag;
	logic             subtract_flag;
	logic             half_flag;
	logic             carry_flag;

	logic [7:0] accum_q = '0;
	flags_t     flags_q = '0;
	alu_out_t   pending_alu_results [$];
	int         mismatch_count = 0;
	int         cycle_count = 0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;

	cpu_accumulator_alu_flags DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.operand       (operand),
		.pair_value    (pair_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.acc_out       (acc_out),
		.result        (result),
		.zero_flag     (zero_flag),
		.subtract_flag (subtract_flag),
		.half_flag     (half_flag),
		.carry_flag    (carry_flag)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// next accumulator, result and flags; advances the predicted state
	function automatic alu_out_t alu_predict(logic [ModeW-1:0] m, logic [15:0] opw,
		logic [15:0] hl);
		logic [7:0]  a;
		logic [7:0]  b;
		logic [7:0]  na;
		logic [7:0]  hx;
		logic [7:0]  adj;
		logic [8:0]  sum9;
		logic [15:0] diff16;
		logic [15:0] hx16;
		logic [16:0] sum17;
		logic [15:0] res;
		flags_t      f;
		flags_t      nf;
		alu_out_t    o;
		a = accum_q;
		b = opw[7:0];
		f = flags_q;
		na = a;
		nf = f;
		res = '0;
		case (m) inside
			MODE_ADD, MODE_ADC: begin
				sum9 = {1'b0, a} + {1'b0, b} + {8'h00, (m == MODE_ADC) && f.c};
				hx = a ^ b ^ sum9[7:0];
				na = sum9[7:0];
				nf.z = (na == 8'h00);
				nf.n = 1'b0;
				nf.h = hx[4];
				nf.c = sum9[8];
			end
			MODE_SUB, MODE_SBC, MODE_CP: begin
				diff16 = {8'h00, a} - {8'h00, b} - {15'h0000, (m == MODE_SBC) && f.c};
				hx = a ^ b ^ diff16[7:0];
				nf.z = (diff16[7:0] == 8'h00);
				nf.n = 1'b1;
				nf.h = hx[4];
				nf.c = diff16[8];
				if (m != MODE_CP) begin
					na = diff16[7:0];
				end
			end
			MODE_AND, MODE_XOR, MODE_OR: begin
				na = (m == MODE_AND) ? (a & b) : (m == MODE_XOR) ? (a ^ b) : (a | b);
				nf.z = (na == 8'h00);
				nf.n = 1'b0;
				nf.h = (m == MODE_AND);
				nf.c = 1'b0;
			end
			MODE_INC: begin
				res = {8'h00, b + 8'd1};
				nf.z = (b == 8'hFF);
				nf.n = 1'b0;
				nf.h = (b[3:0] == 4'hF);
			end
			MODE_DEC: begin
				res = {8'h00, b - 8'd1};
				nf.z = (b == 8'h01);
				nf.n = 1'b1;
				nf.h = (b[3:0] == 4'h0);
			end
			MODE_RLCA, MODE_RRCA, MODE_RLA, MODE_RRA: begin
				case (m)
					MODE_RLCA: na = {a[6:0], a[7]};
					MODE_RRCA: na = {a[0], a[7:1]};
					MODE_RLA:  na = {a[6:0], f.c};
					default:   na = {f.c, a[7:1]};
				endcase
				nf.z = 1'b0;
				nf.n = 1'b0;
				nf.h = 1'b0;
				nf.c = (m == MODE_RLCA || m == MODE_RLA) ? a[7] : a[0];
			end
			MODE_DAA: begin
				adj = 8'h00;
				if (f.h) adj = adj | DAA_LO_ADJ;
				if (f.c) adj = adj | DAA_HI_ADJ;
				if (f.n) begin
					na = a - adj;
				end else begin
					if (a[3:0] > DAA_LO_MAX) adj = adj | DAA_LO_ADJ;
					if (a > DAA_MAX) adj = adj | DAA_HI_ADJ;
					na = a + adj;
				end
				nf.z = (na == 8'h00);
				nf.h = 1'b0;
				nf.c = ((adj & DAA_HI_ADJ) != 8'h00);
			end
			MODE_CPL: begin
				na = ~a;
				nf.n = 1'b1;
				nf.h = 1'b1;
			end
			MODE_SCF, MODE_CCF: begin
				nf.n = 1'b0;
				nf.h = 1'b0;
				nf.c = (m == MODE_SCF) ? 1'b1 : ~f.c;
			end
			MODE_ADD16: begin
				sum17 = {1'b0, hl} + {1'b0, opw};
				hx16 = hl ^ opw ^ sum17[15:0];
				res = sum17[15:0];
				nf.n = 1'b0;
				nf.h = hx16[12];
				nf.c = sum17[16];
			end
			MODE_LDA: na = b;
			default: ;
		endcase
		accum_q = na;
		flags_q = nf;
		o.acc = na;
		o.res = res;
		o.fl = nf;
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0h, want %0h", what, got, want);
		mismatch_count++;
	endtask

	task automatic send_request(logic [ModeW-1:0] m, logic [15:0] opw, logic [15:0] hl,
		logic typed, alu_out_t typed_want);
		alu_out_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		operand <= opw;
		pair_value <= hl;
		do @(posedge clk); while (in_stall);
		predicted = alu_predict(m, opw, hl);
		pending_alu_results.push_back(typed ? typed_want : predicted);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_alu_results.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		alu_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_alu_results.size() == 0) begin
				report_mismatch("result with no request pending", int'(acc_out), 0);
			end else begin
				want = pending_alu_results.pop_front();
				if (acc_out !== want.acc)
					report_mismatch("acc_out", int'(acc_out), int'(want.acc));
				if (result !== want.res)
					report_mismatch("result", int'(result), int'(want.res));
				if (zero_flag !== want.fl.z)
					report_mismatch("zero_flag", int'(zero_flag), int'(want.fl.z));
				if (subtract_flag !== want.fl.n)
					report_mismatch("subtract_flag", int'(subtract_flag), int'(want.fl.n));
				if (half_flag !== want.fl.h)
					report_mismatch("half_flag", int'(half_flag), int'(want.fl.h));
				if (carry_flag !== want.fl.c)
					report_mismatch("carry_flag", int'(carry_flag), int'(want.fl.c));
			end
		end
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	initial begin
		logic [ModeW-1:0] m;
		logic [15:0]      opw;
		logic [15:0]      hl;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 19;
		recv_stall_pct = 46;
		for (int i = 0; i < NDIR; i++) begin
			send_request(DIR_TABLE[i].mode, DIR_TABLE[i].operand, DIR_TABLE[i].pair,
				DIR_TABLE[i].typed, DIR_TABLE[i].want);
		end

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 46 : 0;
			recv_stall_pct = (phase == 0) ? 46 : (phase == 1) ? 19 : 0;
			drain_results();
			for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					m = ModeW'($urandom_range(MODE_LDA + 1, MODE_NOP));
				end else begin
					m = ModeW'($urandom_range(MODE_ADD, MODE_LDA));
				end
				opw = 16'($urandom_range(0, 16'hFFFF));
				hl = 16'($urandom_range(0, 16'hFFFF));
				// corner bytes now and then so the flag edges show up often
				if ($urandom_range(0, 4) == 0) begin
					case ($urandom_range(0, 7))
						0: opw[7:0] = 8'h00;
						1: opw[7:0] = 8'h01;
						2: opw[7:0] = 8'h0F;
						3: opw[7:0] = 8'h10;
						4: opw[7:0] = 8'h7F;
						5: opw[7:0] = 8'h80;
						6: opw[7:0] = 8'h99;
						default: opw[7:0] = 8'hFF;
					endcase
				end
				if ($urandom_range(0, 199) == 0) drain_results();
				send_request(m, opw, hl, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (pending_alu_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
